/* hdl/bse_pkg.sv */
// Package for the burning ship escape-time block.
// Shared widths, constants, register indexes and the queue item type.
// No dependencies.
`default_nettype none
package bse_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int PIX_W         = 11;
  localparam int CNT_W         = 10;
  localparam int STEP_W        = 31;
  localparam int ORG_W         = 32;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  // c never exceeds 44 signed bits; one spare
  localparam int C_W           = 45;
  // z components stay below 2.0 while iterating
  localparam int Z_W           = FRAC_BITS + 1;
  localparam int CENTER_OFFSET = 650;
  localparam int FIFO_DEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_STEP  = 8'd0,
    REG_ORIGIN_REAL = 8'd1,
    REG_ORIGIN_IMAG = 8'd2,
    REG_MAX_ITER    = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0]     px;
    logic [PIX_W-1:0]     py;
    logic signed [C_W-1:0] cr;
    logic signed [C_W-1:0] ci;
  } pt_item_t;

endpackage
`default_nettype wire

/* hdl/burning_ship_escape_time.sv */
// Top level of the burning ship escape-time block: config registers,
// mapper front end, point queue and iteration engine.
// Depends on bse_pkg, bse_map, bse_fifo, bse_core.
//
// Usage:
//  - in_* stream: one item per pixel, tdata = {pixel_y, pixel_x} (zero padded).
//  - out_* stream: one item per pixel, tdata = {iteration_count, out_y, out_x},
//    tuser = escaped.
//  - cfg_*: register writes (index, data), always ready; write only while idle.
//  - Path: an accepted item is registered in the mapper, written into the
//    queue, then loaded by the engine when it is idle; each iteration is a
//    multiply pass, then an add/abs/compare pass. The result is registered
//    at the end of the add pass when a component reaches 2.0, and after a
//    further multiply and add pass when the magnitude test or the limit
//    ends the run. The engine takes a new item only after finishing the
//    last one, so its iteration loop sets the throughput.
//  - The mapper and queue keep accepting items while the engine iterates,
//    up to the queue depth plus one staged item.
//  - Reset (rst_n low, synchronous) empties the pipeline and restores the
//    register defaults.
//  - A stalled receiver holds the result in the output register; the engine
//    finishes its current point and waits, and the queue fills behind it.
`default_nettype none
module burning_ship_escape_time #(
  parameter int FIFO_DEPTH = bse_pkg::FIFO_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [23:0]                       in_tdata,   // pixel_x, pixel_y
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [31:0]                       out_tdata,  // out_x, out_y, iteration_count
  output logic                              out_tuser,  // escaped
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [bse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bse_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bse_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [ORG_W-1:0]  org_re_r, org_im_r;
  logic [CNT_W-1:0]  max_it_r;

  pt_item_t          map_item, q_item;
  logic              map_push, q_ready, q_valid, q_pop;
  logic [PIX_W-1:0]  rx, ry;
  logic [CNT_W-1:0]  rcnt;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_W'(55924);
      org_re_r <= '0;
      org_im_r <= '0;
      max_it_r <= CNT_W'(50);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PIXEL_STEP:  step_r   <= cfg_data[STEP_W-1:0];
        REG_ORIGIN_REAL: org_re_r <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_IMAG: org_im_r <= cfg_data[ORG_W-1:0];
        REG_MAX_ITER:    max_it_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  bse_map u_map (
    .clk, .rst_n,
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .px         (in_tdata[PIX_W-1:0]),
    .py         (in_tdata[2*PIX_W-1:PIX_W]),
    .pixel_step (step_r),
    .origin_real(org_re_r),
    .origin_imag(org_im_r),
    .push       (map_push),
    .push_ready (q_ready),
    .item       (map_item)
  );

  bse_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n,
    .push       (map_push),
    .push_ready (q_ready),
    .push_item  (map_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  bse_core u_core (
    .clk, .rst_n,
    .pt_valid  (q_valid),
    .pt_pop    (q_pop),
    .pt        (q_item),
    .max_iter  (max_it_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_x     (rx),
    .res_y     (ry),
    .res_cnt   (rcnt),
    .res_esc   (out_tuser)
  );

  assign out_tdata = {rcnt, ry, rx};

endmodule
`default_nettype wire

/* hdl/bse_map.sv */
// Front end: accepts pixel items and maps them to complex points.
// Depends on bse_pkg.
`default_nettype none
module bse_map (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [bse_pkg::PIX_W-1:0]   px,
  input  wire  [bse_pkg::PIX_W-1:0]   py,
  input  wire  [bse_pkg::STEP_W-1:0]  pixel_step,
  input  wire  [bse_pkg::ORG_W-1:0]   origin_real,
  input  wire  [bse_pkg::ORG_W-1:0]   origin_imag,
  output logic                        push,
  input  wire                         push_ready,
  output bse_pkg::pt_item_t           item
);
  import bse_pkg::*;

  localparam int OFF_W = PIX_W + 1;
  localparam int PRD_W = OFF_W + STEP_W + 1;

  logic              valid_r, valid_nxt;
  pt_item_t          item_r;
  logic signed [OFF_W-1:0]  offx, offy;
  logic signed [STEP_W:0]   step_s;
  logic signed [PRD_W-1:0]  mulx, muly;
  logic signed [C_W-1:0]    crx, ciy;

  assign in_ready = !valid_r || push_ready;
  assign push     = valid_r;
  assign item     = item_r;

  always_comb begin
    offx   = $signed({1'b0, px}) - $signed(OFF_W'(CENTER_OFFSET));
    offy   = $signed({1'b0, py}) - $signed(OFF_W'(CENTER_OFFSET));
    step_s = $signed({1'b0, pixel_step});
    mulx   = offx * step_s;
    muly   = offy * step_s;
    crx    = C_W'(mulx) + C_W'($signed(origin_real));
    ciy    = C_W'(muly) + C_W'($signed(origin_imag));
    valid_nxt = valid_r;
    if (in_valid && in_ready) valid_nxt = 1'b1;
    else if (push_ready)      valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    if (in_valid && in_ready) begin
      item_r.px <= px;
      item_r.py <= py;
      item_r.cr <= crx;
      item_r.ci <= ciy;
    end
  end

endmodule
`default_nettype wire

/* hdl/bse_fifo.sv */
// Short register queue between the mapper and the iteration engine.
// Depends on bse_pkg.
`default_nettype none
module bse_fifo #(
  parameter int DEPTH = bse_pkg::FIFO_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  output logic               push_ready,
  input  bse_pkg::pt_item_t  push_item,
  output logic               pop_valid,
  input  wire                pop,
  output bse_pkg::pt_item_t  pop_item
);
  import bse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W2 = $clog2(DEPTH + 1);

  pt_item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W2-1:0]     cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign push_ready = cnt_r != CNT_W2'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (do_push) wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + CNT_W2'(do_push) - CNT_W2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

/* hdl/bse_core.sv */
// Back end: iterates the burning ship map for one point and holds the result.
// Depends on bse_pkg.
`default_nettype none
module bse_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         pt_valid,
  output logic                        pt_pop,
  input  bse_pkg::pt_item_t           pt,
  input  wire  [bse_pkg::CNT_W-1:0]   max_iter,
  output logic                        res_valid,
  input  wire                         res_ready,
  output logic [bse_pkg::PIX_W-1:0]   res_x,
  output logic [bse_pkg::PIX_W-1:0]   res_y,
  output logic [bse_pkg::CNT_W-1:0]   res_cnt,
  output logic                        res_esc
);
  import bse_pkg::*;

  localparam int SQ_W  = 2 * Z_W;
  localparam int SR_W  = SQ_W - FRAC_BITS;
  localparam int PR_W  = SQ_W - FRAC_BITS + 1;
  localparam int N_W   = C_W + 2;
  localparam logic [SQ_W:0] FOUR_WIDE = (SQ_W + 1)'(4) << (2 * FRAC_BITS);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} state_t;

  state_t                 state_r;
  logic [Z_W-1:0]         zr_r, zi_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [C_W-1:0]  cr_r, ci_r;
  logic [PIX_W-1:0]       px_r, py_r;
  logic [SQ_W-1:0]        sqr_r, sqi_r, prd_r;
  logic                   ov_r, oesc_r;
  logic [PIX_W-1:0]       ox_r, oy_r;
  logic [CNT_W-1:0]       ocnt_r;

  logic [SQ_W:0]          mag;
  logic                   esc_now, at_max, big, finish, fin_esc, out_free;
  logic                   load_out;
  logic signed [N_W-1:0]  nr, ni;
  logic [N_W-1:0]         ar, ai;
  logic [CNT_W-1:0]       cnt_inc, fin_cnt;

  assign out_free  = !ov_r || res_ready;
  assign load_out  = (state_r == S_ADD) && finish && out_free;
  assign pt_pop    = (state_r == S_IDLE) && pt_valid;
  assign res_valid = ov_r;
  assign res_x     = ox_r;
  assign res_y     = oy_r;
  assign res_cnt   = ocnt_r;
  assign res_esc   = oesc_r;

  always_comb begin
    mag     = {1'b0, sqr_r} + {1'b0, sqi_r};
    // squares of the current z double as its escape test
    esc_now = (cnt_r != '0) && (mag >= FOUR_WIDE);
    at_max  = cnt_r == max_iter;
    nr = $signed({(N_W - SR_W)'(0), sqr_r[SQ_W-1:FRAC_BITS]})
       - $signed({(N_W - SR_W)'(0), sqi_r[SQ_W-1:FRAC_BITS]})
       + N_W'(cr_r);
    ni = $signed({(N_W - PR_W)'(0), prd_r[SQ_W-1:FRAC_BITS-1]}) + N_W'(ci_r);
    ar = nr[N_W-1] ? N_W'(-nr) : N_W'(nr);
    ai = ni[N_W-1] ? N_W'(-ni) : N_W'(ni);
    // a component of 2.0 or more escapes without squaring, unless the count is at the limit
    big     = (|ar[N_W-1:Z_W]) || (|ai[N_W-1:Z_W]);
    cnt_inc = cnt_r + 1'b1;
    finish  = esc_now || at_max || big;
    fin_esc = esc_now || (!at_max && big);
    fin_cnt = (esc_now || at_max) ? cnt_r : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load_out)       ov_r <= 1'b1;
      else if (res_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pt_valid) begin
            state_r <= S_MUL;
            zr_r    <= '0;
            zi_r    <= '0;
            cnt_r   <= '0;
            cr_r    <= pt.cr;
            ci_r    <= pt.ci;
            px_r    <= pt.px;
            py_r    <= pt.py;
          end
        end
        S_MUL: begin
          sqr_r   <= zr_r * zr_r;
          sqi_r   <= zi_r * zi_r;
          prd_r   <= zr_r * zi_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (!finish) begin
            zr_r    <= ar[Z_W-1:0];
            zi_r    <= ai[Z_W-1:0];
            cnt_r   <= cnt_inc;
            state_r <= S_MUL;
          end else if (out_free) begin
            ox_r    <= px_r;
            oy_r    <= py_r;
            ocnt_r  <= fin_cnt;
            oesc_r  <= fin_esc;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_esc |-> res_cnt == max_iter)
    else $error("non-escaped result count differs from limit");
  a_esc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_esc |-> res_cnt != '0)
    else $error("escape reported with zero iterations");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> cnt_r <= max_iter)
    else $error("iteration count ran past limit");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_cnt) && $stable(res_esc))
    else $error("pending result changed while stalled");

endmodule
`default_nettype wire

/* tb/sv/burning_ship_escape_time_test.sv */
// Testbench for burning_ship_escape_time: drives pixel items and register
// writes, predicts count and escape flag in Q8.24, checks every result item.
// Depends on bse_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none

class escape_scoreboard;
  // predicted result fields, oldest first
  logic [10:0] want_x[$];
  logic [10:0] want_y[$];
  logic [9:0]  want_cnt[$];
  logic        want_esc[$];
  int          mismatches;

  // register shadows
  logic [30:0] step;
  logic signed [31:0] org_r;
  logic signed [31:0] org_i;
  logic [9:0]  iter_limit;

  function void reset_regs();
    step = 31'd55924;
    org_r = 0;
    org_i = 0;
    iter_limit = 10'd50;
  endfunction

  function void write_reg(logic [7:0] idx, logic [31:0] val);
    case (idx)
      bse_pkg::REG_PIXEL_STEP:  step = val[30:0];
      bse_pkg::REG_ORIGIN_REAL: org_r = val;
      bse_pkg::REG_ORIGIN_IMAG: org_i = val;
      bse_pkg::REG_MAX_ITER:    iter_limit = val[9:0];
      default: ;
    endcase
  endfunction

  // iterate one pixel and queue its expected result
  function void note_pixel(logic [10:0] px, logic [10:0] py);
    logic signed [63:0] cr, ci, zr, zi, sr, si, pr;
    logic [127:0] mag;
    logic [9:0] cnt;
    logic esc;
    cr = ($signed({53'd0, px}) - 64'sd650) * $signed({33'd0, step}) + org_r;
    ci = ($signed({53'd0, py}) - 64'sd650) * $signed({33'd0, step}) + org_i;
    zr = 0;
    zi = 0;
    cnt = 0;
    esc = 0;
    while (!esc && cnt < iter_limit) begin
      sr = (zr * zr) >>> 24;
      si = (zi * zi) >>> 24;
      pr = (zr * zi) >>> 23;
      zr = sr - si + cr;
      if (zr < 0) zr = -zr;
      zi = pr + ci;
      if (zi < 0) zi = -zi;
      cnt++;
      if (zr >= (64'sd2 <<< 24) || zi >= (64'sd2 <<< 24)) begin
        esc = 1;
      end else begin
        mag = {64'd0, zr} * {64'd0, zr} + {64'd0, zi} * {64'd0, zi};
        esc = mag >= (128'd4 << 48);
      end
    end
    want_x.push_back(px);
    want_y.push_back(py);
    want_cnt.push_back(cnt);
    want_esc.push_back(esc);
  endfunction

  function void check_result(logic [31:0] tdata, logic tuser);
    logic [10:0] ex, ey;
    logic [9:0] ec;
    logic ee;
    if (want_x.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h/%b", tdata, tuser);
      return;
    end
    ex = want_x.pop_front();
    ey = want_y.pop_front();
    ec = want_cnt.pop_front();
    ee = want_esc.pop_front();
    if (tdata[10:0] !== ex || tdata[21:11] !== ey || tdata[31:22] !== ec || tuser !== ee) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: want x=%0d y=%0d cnt=%0d esc=%b, got x=%0d y=%0d cnt=%0d esc=%b",
                 ex, ey, ec, ee, tdata[10:0], tdata[21:11], tdata[31:22], tuser);
    end
  endfunction

  function int pending();
    return want_x.size();
  endfunction
endclass

module burning_ship_escape_time_test;
  import bse_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = 0;     // pixel_x, pixel_y
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;        // out_x, out_y, iteration_count
  logic out_tuser;               // escaped
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  escape_scoreboard pixels_sb;
  int send_idle_pct;    // chance in 100 that the sender idles a cycle
  int recv_stall_pct;   // chance in 100 that the receiver stalls
  int cycles;
  int limit_cycles;

  burning_ship_escape_time uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stall, check at each accepting edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      pixels_sb.check_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles > limit_cycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One register write; only called while the block is idle.
  task automatic write_cfg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    pixels_sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  // Send one pixel item, with optional idle cycles before it.
  task automatic send_pixel(input logic [10:0] px, input logic [10:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b00, py, px};
    do @(posedge clk); while (!in_tready);
    pixels_sb.note_pixel(px, py);
  endtask

  task automatic end_burst();
    in_tvalid <= 0;
  endtask

  // Wait for all results, then a few quiet cycles before the next settings.
  task automatic drain();
    end_burst();
    while (pixels_sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  // Mostly small steps around an origin near the set keep iterating long; some phases use the largest or a random step.
  task automatic random_config(input int phase);
    case (phase % 5)
      0: write_cfg(REG_PIXEL_STEP, $urandom_range(200000, 1000));
      1: write_cfg(REG_PIXEL_STEP, $urandom_range(20000, 0));
      2: write_cfg(REG_PIXEL_STEP, 32'h7FFF_FFFF);
      3: write_cfg(REG_PIXEL_STEP, $urandom_range(4000, 1));
      default: write_cfg(REG_PIXEL_STEP, $urandom);
    endcase
    write_cfg(REG_ORIGIN_REAL, (phase % 3 == 0) ? $urandom : $signed($urandom_range(67108864)) - 32'sd33554432);
    write_cfg(REG_ORIGIN_IMAG, (phase % 3 == 0) ? $urandom : $signed($urandom_range(67108864)) - 32'sd33554432);
    write_cfg(REG_MAX_ITER, (phase % 4 == 1) ? 10'd1023 : $urandom_range(120, 0));
  endtask

  initial begin
    logic [10:0] rx, ry;
    int phase;
    pixels_sb = new();
    pixels_sb.reset_regs();
    // slowest item: the limit of 1023 iterations plus stalls; kept far above typical
    limit_cycles = 3000000;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset defaults, field extremes, outside-image pixels.
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd2047);
    send_pixel(11'd650, 11'd650);
    send_pixel(11'd1024, 11'd1023);
    send_pixel(11'h555, 11'h2AA);
    send_pixel(11'h2AA, 11'h555);
    drain();
    // Zero limit: count 0, not escaped.
    write_cfg(REG_MAX_ITER, 0);
    send_pixel(11'd0, 11'd2047);
    send_pixel(11'd650, 11'd650);
    drain();
    // Escape right on the last pass with limit 1 and a far point.
    write_cfg(REG_MAX_ITER, 1);
    write_cfg(REG_PIXEL_STEP, 32'h7FFF_FFFF);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd650);
    drain();
    // Extreme origins, max limit, unused index ignored.
    write_cfg(REG_ORIGIN_REAL, 32'h8000_0000);
    write_cfg(REG_ORIGIN_IMAG, 32'h7FFF_FFFF);
    write_cfg(8'd7, 32'hFFFF_FFFF);
    write_cfg(REG_MAX_ITER, 32'd1023);
    write_cfg(REG_PIXEL_STEP, 1);
    send_pixel(11'd650, 11'd650);
    send_pixel(11'd2047, 11'd0);
    drain();
    // Points in the set next to the origin: run the full limit.
    write_cfg(REG_ORIGIN_REAL, 0);
    write_cfg(REG_ORIGIN_IMAG, 0);
    send_pixel(11'd650, 11'd651);
    send_pixel(11'd649, 11'd650);
    drain();

    // Random phases of 50 pixels each, new settings between phases.
    for (phase = 0; phase < 20; phase++) begin
      set_idling(phase);
      random_config(phase);
      repeat (50) begin
        rx = $urandom_range(2047);
        ry = $urandom_range(2047);
        if ($urandom_range(3) != 0) begin
          rx = 11'd650 + $signed($urandom_range(60)) - 30;
          ry = 11'd650 + $signed($urandom_range(60)) - 30;
        end
        send_pixel(rx, ry);
        if ($urandom_range(9) == 0) begin
          end_burst();
          @(posedge clk);
        end
      end
      drain();
    end

    if (pixels_sb.mismatches == 0 && pixels_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
hdl/bse_pkg.sv
hdl/bse_map.sv
hdl/bse_fifo.sv
hdl/bse_core.sv
hdl/burning_ship_escape_time.sv
tb/sv/burning_ship_escape_time_test.sv
